// ===== rtl/epsz_pkg.sv =====
// Package: shared types and codes of the encoder positioner with slow zone.
package epsz_pkg;

   localparam int unsigned PosWidth  = 32;
   localparam int unsigned SlowWidth = 31;
   localparam int unsigned DutyWidth = 8;
   localparam int unsigned CsrWidth  = SlowWidth;

   // event kinds carried in the mode field
   typedef enum logic [1:0] {
      MODE_MOVE  = 2'd0,
      MODE_EDGE  = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SLOW_DISTANCE = 2'd0,
      CSR_MIN_DUTY      = 2'd1,
      CSR_MAX_DUTY      = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [SlowWidth-1:0] SlowDistanceReset = SlowWidth'(100);
   localparam logic [DutyWidth-1:0] MinDutyReset      = DutyWidth'(80);
   localparam logic [DutyWidth-1:0] MaxDutyReset      = DutyWidth'(255);

   typedef struct packed {
      logic [SlowWidth-1:0] slow_distance;
      logic [DutyWidth-1:0] min_duty;
      logic [DutyWidth-1:0] max_duty;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [PosWidth-1:0] target;
      logic                enc_a;
      logic                enc_b;
      logic                end_one;
      logic                end_two;
   } item_type;

   typedef struct packed {
      logic [PosWidth-1:0]  position;
      logic [PosWidth-1:0]  goal;
      logic                 moving_fwd;
      logic                 stopped;
      logic [DutyWidth-1:0] duty;
      logic                 fwd;
      logic                 bwd;
      logic                 led;
   } state_type;

endpackage

// ===== rtl/epsz_req_if.sv =====
// Interface: event word channel into the positioner.
interface epsz_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic signed [31:0]  target;
   logic                enc_a;
   logic                enc_b;
   logic                end_one;
   logic                end_two;

   modport source (output valid, mode, target, enc_a, enc_b, end_one, end_two,
                   input ready);
   modport sink   (input valid, mode, target, enc_a, enc_b, end_one, end_two,
                   output ready);
endinterface

// ===== rtl/epsz_rsp_if.sv =====
// Interface: status word channel out of the positioner.
interface epsz_rsp_if;
   logic                valid;
   logic                ready;
   logic                drive_fwd;
   logic                drive_bwd;
   logic [7:0]          duty;
   logic                indicator;
   logic signed [31:0]  position;
   logic                halted;

   modport source (output valid, drive_fwd, drive_bwd, duty, indicator, position, halted,
                   input ready);
   modport sink   (input valid, drive_fwd, drive_bwd, duty, indicator, position, halted,
                   output ready);
endinterface

// ===== rtl/epsz_step.sv =====
// Next-state logic for one event word.
module epsz_step (
   input  epsz_pkg::state_type cur_st,
   input  epsz_pkg::item_type  item,
   input  epsz_pkg::cfg_type   cfg,
   output epsz_pkg::state_type nxt_st
);
   import epsz_pkg::*;

   logic [PosWidth:0]   mv_diff;   // target - position, exact
   logic [PosWidth-1:0] mv_mag;
   logic                mv_fwd;
   logic                mv_near;
   logic [PosWidth-1:0] pos_step;
   logic [PosWidth:0]   gl_diff;   // goal - new position, exact
   logic [PosWidth-1:0] gl_mag;
   logic                gl_near;
   logic                gl_reached;

   always_comb begin
      // move command terms
      mv_diff = {item.target[PosWidth-1], item.target}
              - {cur_st.position[PosWidth-1], cur_st.position};
      mv_fwd  = !mv_diff[PosWidth];
      mv_mag  = mv_fwd ? mv_diff[PosWidth-1:0] : (~mv_diff[PosWidth-1:0] + 1'b1);
      mv_near = mv_mag < {1'b0, cfg.slow_distance};

      // encoder edge terms
      pos_step = (item.enc_a == item.enc_b) ? cur_st.position + 1'b1
                                             : cur_st.position - 1'b1;
      gl_diff  = {cur_st.goal[PosWidth-1], cur_st.goal} - {pos_step[PosWidth-1], pos_step};
      if (cur_st.moving_fwd) begin
         gl_reached = gl_diff[PosWidth] || (gl_diff == '0);
         gl_mag     = gl_diff[PosWidth-1:0];
      end else begin
         gl_reached = !gl_diff[PosWidth];
         gl_mag     = ~gl_diff[PosWidth-1:0] + 1'b1;
      end
      gl_near = gl_mag < {1'b0, cfg.slow_distance};

      nxt_st = cur_st;
      case (mode_type'(item.mode))
         MODE_MOVE: begin
            if (mv_diff != '0 && !item.end_one && !item.end_two) begin
               nxt_st.goal       = item.target;
               nxt_st.moving_fwd = mv_fwd;
               nxt_st.fwd        = mv_fwd;
               nxt_st.bwd        = !mv_fwd;
               nxt_st.led        = mv_fwd;
               nxt_st.stopped    = 1'b0;
               nxt_st.duty       = mv_near ? cfg.min_duty : cfg.max_duty;
            end
         end
         MODE_EDGE: begin
            nxt_st.position = pos_step;
            if (!cur_st.stopped) begin
               if (gl_reached) begin
                  nxt_st.fwd     = 1'b0;
                  nxt_st.bwd     = 1'b0;
                  nxt_st.led     = 1'b0;
                  nxt_st.duty    = cfg.max_duty;
                  nxt_st.stopped = 1'b1;
               end else if (gl_near) begin
                  nxt_st.duty = cfg.min_duty;
               end
            end
         end
         MODE_STOP: begin
            nxt_st.fwd     = 1'b0;
            nxt_st.bwd     = 1'b0;
            nxt_st.led     = 1'b0;
            nxt_st.duty    = cfg.max_duty;
            nxt_st.stopped = 1'b1;
         end
         default: begin
            nxt_st = cur_st;
         end
      endcase
   end

endmodule

// ===== rtl/encoder_positioner_with_slow_zone.sv =====
// Top level: quadrature encoder bang-bang positioner with a slow zone.
//
// Each accepted event word (move command, encoder A edge or end-stop hit) updates
// the position counter or the motor drive state in the same cycle and returns one
// status word in the next cycle: drive lines, duty, LED, position and halted flag
// as they stand after the event. A new word is accepted every clock while the
// status register is free or being taken: the status register empties as
// it is taken, so ready only drops while it is full and stalled. The limiting
// path is the encoder update (increment, 33-bit subtract to the goal, compare
// with slow_distance). csr_ writes take effect on the next event; write them
// only while the block is idle.
module encoder_positioner_with_slow_zone (
   input  logic                           clock,
   input  logic                           reset,
   epsz_req_if.sink                       req_if,
   epsz_rsp_if.source                     rsp_if,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [epsz_pkg::CsrWidth-1:0]  csr_wdata
);
   import epsz_pkg::*;

   cfg_type   cfg_ff;
   state_type st_ff, st_in;
   item_type  item;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type rsp_ff;
   logic      req_take;

   // a word is taken whenever the status register is free or being drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   assign item = '{mode:    req_if.mode,
                   target:  req_if.target,
                   enc_a:   req_if.enc_a,
                   enc_b:   req_if.enc_b,
                   end_one: req_if.end_one,
                   end_two: req_if.end_two};

   epsz_step u_step (
      .cur_st (st_ff),
      .item   (item),
      .cfg    (cfg_ff),
      .nxt_st (st_in)
   );

   // configuration registers; unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_distance <= SlowDistanceReset;
         cfg_ff.min_duty      <= MinDutyReset;
         cfg_ff.max_duty      <= MaxDutyReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SLOW_DISTANCE: cfg_ff.slow_distance <= csr_wdata;
            CSR_MIN_DUTY:      cfg_ff.min_duty      <= csr_wdata[DutyWidth-1:0];
            CSR_MAX_DUTY:      cfg_ff.max_duty      <= csr_wdata[DutyWidth-1:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   // motor and position state: stopped after reset, everything else clear
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{stopped: 1'b1, default: '0};
      end else if (req_take) begin
         st_ff <= st_in;
      end
   end

   // status word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= st_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.drive_fwd = rsp_ff.fwd;
   assign rsp_if.drive_bwd = rsp_ff.bwd;
   assign rsp_if.duty      = rsp_ff.duty;
   assign rsp_if.indicator = rsp_ff.led;
   assign rsp_if.position  = rsp_ff.position;
   assign rsp_if.halted    = rsp_ff.stopped;

   // bridge must never see both drive lines at once
   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.fwd && st_ff.bwd))
      else $error("both drive lines active");

   // a stopped motor has no drive line set
   a_stopped_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff.stopped |-> (!st_ff.fwd && !st_ff.bwd && !st_ff.led))
      else $error("drive active while stopped");

   // LED tracks forward drive
   a_led_fwd: assert property (@(posedge clock) disable iff (reset)
      st_ff.led == st_ff.fwd)
      else $error("LED out of step with forward drive");

   // every taken word produces a status word next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("status word missing after accepted event");

endmodule
